[src/bmm_pkg.sv]
`default_nettype none

package bmm_pkg;

  // Default sizes of the graph
  localparam int unsigned MAX_LEFT_DEF  = 32;
  localparam int unsigned MAX_RIGHT_DEF = 32;

  // Field widths
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned VERTEX_W  = 5;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned CFG_IDX_W = 1;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SOLVE    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COUNT = 1'b1;

  // Source of the adjacency read address
  typedef enum logic [1:0] {
    ADJ_SEL_INPUT = 2'd0,
    ADJ_SEL_ROOT  = 2'd1,
    ADJ_SEL_CUR   = 2'd2
  } adj_sel_e;

  // Controller to datapath
  typedef struct packed {
    adj_sel_e adj_sel;
    logic     edge_latch;
    logic     adj_clear;
    logic     adj_write;
    logic     solve_init;
    logic     root_first;
    logic     root_next;
    logic     try_start;
    logic     pick;
    logic     pop;
    logic     pop_load;
    logic     push;
    logic     augment_end;
    logic     flip_write;
    logic     emit_load;
    logic     emit_zero;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic edge_ok;
    logic lc_zero;
    logic root_last;
    logic root_has_edge;
    logic cand_any;
    logic owner_taken;
    logic sp_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

[src/bmm_ctrl.sv]
`default_nettype none

module bmm_ctrl import bmm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire ctrl_sts_t           sts_i,
  output ctrl_cmd_t                cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_ADD_WR    = 12'b0000_0000_0010,
    ST_ROOT_RD   = 12'b0000_0000_0100,
    ST_ROOT_CHK  = 12'b0000_0000_1000,
    ST_ADJ_RD    = 12'b0000_0001_0000,
    ST_PICK      = 12'b0000_0010_0000,
    ST_OWN_CHK   = 12'b0000_0100_0000,
    ST_POP_WAIT  = 12'b0000_1000_0000,
    ST_FLIP_WR   = 12'b0001_0000_0000,
    ST_EMIT_RD   = 12'b0010_0000_0000,
    ST_EMIT_WAIT = 12'b0100_0000_0000,
    ST_EMIT_ZERO = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and command decode
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.adj_sel = ADJ_SEL_CUR;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.adj_sel = ADJ_SEL_INPUT;
        if (accept) begin
          cmd_o.edge_latch = 1'b1;
          unique case (opcode_i)
            OP_CLEAR: begin
              cmd_o.adj_clear = 1'b1;
            end
            OP_ADD_EDGE: begin
              if (sts_i.edge_ok) begin
                state_d = ST_ADD_WR;
              end
            end
            OP_SOLVE: begin
              cmd_o.solve_init = 1'b1;
              cmd_o.root_first = 1'b1;
              state_d = sts_i.lc_zero ? ST_EMIT_ZERO : ST_ROOT_RD;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        cmd_o.adj_write = 1'b1;
        state_d = ST_IDLE;
      end
      ST_ROOT_RD: begin
        cmd_o.adj_sel = ADJ_SEL_ROOT;
        state_d = ST_ROOT_CHK;
      end
      ST_ROOT_CHK: begin
        // keep reading the root row so the search sees it next cycle
        cmd_o.adj_sel = ADJ_SEL_ROOT;
        if (sts_i.root_has_edge) begin
          cmd_o.try_start = 1'b1;
          state_d = ST_PICK;
        end else if (sts_i.root_last) begin
          cmd_o.root_first = 1'b1;
          state_d = ST_EMIT_RD;
        end else begin
          cmd_o.root_next = 1'b1;
          state_d = ST_ROOT_RD;
        end
      end
      ST_ADJ_RD: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (sts_i.cand_any) begin
          cmd_o.pick = 1'b1;
          state_d = ST_OWN_CHK;
        end else if (!sts_i.sp_zero) begin
          // dead end: back up one level
          cmd_o.pop = 1'b1;
          state_d = ST_POP_WAIT;
        end else if (sts_i.root_last) begin
          cmd_o.root_first = 1'b1;
          state_d = ST_EMIT_RD;
        end else begin
          cmd_o.root_next = 1'b1;
          state_d = ST_ROOT_RD;
        end
      end
      ST_OWN_CHK: begin
        if (sts_i.owner_taken) begin
          // descend into the current owner of the right vertex
          cmd_o.push = 1'b1;
          state_d = ST_ADJ_RD;
        end else begin
          cmd_o.augment_end = 1'b1;
          if (!sts_i.sp_zero) begin
            cmd_o.pop = 1'b1;
            state_d = ST_FLIP_WR;
          end else if (sts_i.root_last) begin
            cmd_o.root_first = 1'b1;
            state_d = ST_EMIT_RD;
          end else begin
            cmd_o.root_next = 1'b1;
            state_d = ST_ROOT_RD;
          end
        end
      end
      ST_POP_WAIT: begin
        cmd_o.pop_load = 1'b1;
        state_d = ST_ADJ_RD;
      end
      ST_FLIP_WR: begin
        cmd_o.flip_write = 1'b1;
        if (!sts_i.sp_zero) begin
          cmd_o.pop = 1'b1;
        end else if (sts_i.root_last) begin
          cmd_o.root_first = 1'b1;
          state_d = ST_EMIT_RD;
        end else begin
          cmd_o.root_next = 1'b1;
          state_d = ST_ROOT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.root_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.root_next = 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.emit_zero = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/bmm_dpath.sv]
`default_nettype none

module bmm_dpath import bmm_pkg::*; #(
  parameter int unsigned MAX_LEFT  = MAX_LEFT_DEF,
  parameter int unsigned MAX_RIGHT = MAX_RIGHT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COUNT_W-1:0]   cfg_data_i,
  input  wire logic [VERTEX_W-1:0]  left_vertex_i,
  input  wire logic [VERTEX_W-1:0]  right_vertex_i,
  input  wire ctrl_cmd_t            cmd_i,
  output ctrl_sts_t                 sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [VERTEX_W-1:0]       left_id_o,
  output logic [VERTEX_W-1:0]       partner_o,
  output logic                      has_partner_o,
  output logic [COUNT_W-1:0]        match_total_o,
  output logic                      last_o
);

  localparam int unsigned LW     = $clog2(MAX_LEFT);
  localparam int unsigned RW     = $clog2(MAX_RIGHT);
  localparam int unsigned LC_CAP = (MAX_LEFT < 32) ? MAX_LEFT : 32;
  localparam int unsigned SW     = LW + RW;

  // Configuration
  logic [COUNT_W-1:0] left_count_q, right_count_q;
  logic [COUNT_W-1:0] lc;
  logic [6:0]         rc;
  logic [MAX_RIGHT-1:0] rmask;

  // Memories
  logic [MAX_RIGHT-1:0] adj_mem     [MAX_LEFT];
  logic [LW-1:0]        owner_mem   [MAX_RIGHT];
  logic [RW-1:0]        partner_mem [MAX_LEFT];
  logic [SW-1:0]        stack_mem   [MAX_LEFT];

  logic [MAX_LEFT-1:0]  adj_vld_q, partner_vld_q;
  logic [MAX_RIGHT-1:0] owner_vld_q;

  logic [MAX_RIGHT-1:0] adj_rd_q;
  logic                 adj_rd_vld_q;
  logic [LW-1:0]        owner_rd_q;
  logic [RW-1:0]        partner_rd_q;
  logic [SW-1:0]        stack_rd_q;

  // Search state
  logic [MAX_RIGHT-1:0] visited_q;
  logic [LW-1:0]        cur_q, u_q, sp_q;
  logic [RW-1:0]        r_q;
  logic [COUNT_W-1:0]   matched_q;
  logic [LW-1:0]        edge_lv_q;
  logic [RW-1:0]        edge_rv_q;

  // Combinational
  logic [LW-1:0]        adj_raddr;
  logic [MAX_RIGHT-1:0] row_eff, cand, iso, edge_bit;
  logic [RW-1:0]        pick_r;
  logic [LW-1:0]        stk_left;
  logic [RW-1:0]        stk_right;
  logic                 owner_we;
  logic [RW-1:0]        owner_waddr;
  logic [LW-1:0]        owner_wdata;
  logic [LW-1:0]        partner_waddr;
  logic [RW-1:0]        partner_wdata;

  // Effective counts, saturated to the sizes built
  assign lc = (left_count_q > COUNT_W'(LC_CAP)) ? COUNT_W'(LC_CAP) : left_count_q;
  assign rc = ({1'b0, right_count_q} > 7'(MAX_RIGHT)) ? 7'(MAX_RIGHT)
                                                      : {1'b0, right_count_q};

  for (genvar i = 0; i < MAX_RIGHT; i++) begin : g_rmask
    assign rmask[i] = (7'(i) < rc);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_count_q  <= '0;
      right_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_LEFT_COUNT) begin
        left_count_q <= cfg_data_i;
      end else if (cfg_idx_i == REG_RIGHT_COUNT) begin
        right_count_q <= cfg_data_i;
      end
    end
  end

  // Adjacency read address
  always_comb begin
    unique case (cmd_i.adj_sel)
      ADJ_SEL_INPUT: adj_raddr = LW'(left_vertex_i);
      ADJ_SEL_ROOT:  adj_raddr = u_q;
      ADJ_SEL_CUR:   adj_raddr = cur_q;
      default:       adj_raddr = cur_q;
    endcase
  end

  // Row as seen by the search; a row not written since clear reads as empty
  assign row_eff  = adj_rd_vld_q ? adj_rd_q : '0;
  assign edge_bit = {{(MAX_RIGHT-1){1'b0}}, 1'b1} << edge_rv_q;

  // Lowest unvisited usable right vertex
  assign cand = row_eff & rmask & ~visited_q;
  assign iso  = cand & (~cand + {{(MAX_RIGHT-1){1'b0}}, 1'b1});

  always_comb begin
    pick_r = '0;
    for (int unsigned i = 0; i < MAX_RIGHT; i++) begin
      if (iso[i]) begin
        pick_r = pick_r | RW'(i);
      end
    end
  end

  assign stk_left  = stack_rd_q[SW-1:RW];
  assign stk_right = stack_rd_q[RW-1:0];

  // Matching updates: the end of the path, then one stack level a cycle
  assign owner_we      = cmd_i.augment_end || cmd_i.flip_write;
  assign owner_waddr   = cmd_i.augment_end ? r_q : stk_right;
  assign owner_wdata   = cmd_i.augment_end ? cur_q : stk_left;
  assign partner_waddr = owner_wdata;
  assign partner_wdata = owner_waddr;

  // Adjacency memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.adj_write) begin
      adj_mem[edge_lv_q] <= row_eff | edge_bit;
    end
    adj_rd_q     <= adj_mem[adj_raddr];
    adj_rd_vld_q <= adj_vld_q[adj_raddr];
  end

  // Owner, partner and stack memories
  always_ff @(posedge clk_i) begin
    if (owner_we) begin
      owner_mem[owner_waddr]     <= owner_wdata;
      partner_mem[partner_waddr] <= partner_wdata;
    end
    if (cmd_i.push) begin
      stack_mem[sp_q] <= {cur_q, r_q};
    end
    owner_rd_q   <= owner_mem[pick_r];
    partner_rd_q <= partner_mem[u_q];
    stack_rd_q   <= stack_mem[sp_q - 1'b1];
  end

  // Edge latch and picked right vertex
  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_latch) begin
      edge_lv_q <= LW'(left_vertex_i);
      edge_rv_q <= RW'(right_vertex_i);
    end
    if (cmd_i.pick) begin
      r_q <= pick_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q     <= '0;
      owner_vld_q   <= '0;
      partner_vld_q <= '0;
    end else begin
      if (cmd_i.adj_clear) begin
        adj_vld_q <= '0;
      end else if (cmd_i.adj_write) begin
        adj_vld_q[edge_lv_q] <= 1'b1;
      end
      if (cmd_i.solve_init) begin
        owner_vld_q   <= '0;
        partner_vld_q <= '0;
      end else if (owner_we) begin
        owner_vld_q[owner_waddr]     <= 1'b1;
        partner_vld_q[partner_waddr] <= 1'b1;
      end
    end
  end

  // Search control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      cur_q     <= '0;
      sp_q      <= '0;
      u_q       <= '0;
      matched_q <= '0;
    end else begin
      if (cmd_i.try_start) begin
        visited_q <= '0;
      end else if (cmd_i.pick) begin
        visited_q <= visited_q | iso;
      end

      if (cmd_i.try_start) begin
        cur_q <= u_q;
      end else if (cmd_i.pop_load) begin
        cur_q <= stk_left;
      end else if (cmd_i.push) begin
        cur_q <= owner_rd_q;
      end

      if (cmd_i.try_start) begin
        sp_q <= '0;
      end else if (cmd_i.push) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - 1'b1;
      end

      if (cmd_i.root_first) begin
        u_q <= '0;
      end else if (cmd_i.root_next) begin
        u_q <= u_q + 1'b1;
      end

      if (cmd_i.solve_init) begin
        matched_q <= '0;
      end else if (cmd_i.augment_end) begin
        matched_q <= matched_q + 1'b1;
      end
    end
  end

  // Status
  assign sts_o.edge_ok       = (7'(left_vertex_i) < 7'(MAX_LEFT)) &&
                               (7'(right_vertex_i) < 7'(MAX_RIGHT));
  assign sts_o.lc_zero       = (lc == '0);
  assign sts_o.root_last     = ((7'(u_q) + 7'd1) == 7'(lc));
  assign sts_o.root_has_edge = |(row_eff & rmask);
  assign sts_o.cand_any      = |cand;
  assign sts_o.owner_taken   = owner_vld_q[r_q];
  assign sts_o.sp_zero       = (sp_q == '0);
  assign sts_o.out_free      = !out_valid_o || out_ready_i;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.emit_zero) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_zero) begin
      left_id_o     <= '0;
      partner_o     <= '0;
      has_partner_o <= 1'b0;
      match_total_o <= '0;
      last_o        <= 1'b1;
    end else if (cmd_i.emit_load) begin
      left_id_o     <= VERTEX_W'(u_q);
      partner_o     <= partner_vld_q[u_q] ? VERTEX_W'(partner_rd_q) : '0;
      has_partner_o <= partner_vld_q[u_q];
      match_total_o <= matched_q;
      last_o        <= sts_o.root_last;
    end
  end

endmodule

`default_nettype wire

[src/bipartite_max_matching.sv]
`default_nettype none

// Channel   Handshake                  Payload
// config    cfg_we_i                   cfg_idx_i, cfg_data_i
// input     in_valid_i / in_ready_o    opcode_i, left_vertex_i, right_vertex_i
// result    out_valid_o / out_ready_i  left_id_o, partner_o, has_partner_o,
//                                      match_total_o, last_o
//
// Clear drops every row; add edge is a read-modify-write of the row memory.
// Solve searches from each left vertex with a loop of row read, pick and owner
// check, backs up on dead ends, flips each path found, then emits one result per
// left vertex (or one zero result when no left vertex is configured).
// Reset clears counts, valid bits and control; the graph reads as empty.
// Input is taken only between operations; a held result stalls the emit loop.

module bipartite_max_matching import bmm_pkg::*; #(
  parameter int unsigned MAX_LEFT  = MAX_LEFT_DEF,
  parameter int unsigned MAX_RIGHT = MAX_RIGHT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COUNT_W-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OPCODE_W-1:0]  opcode_i,
  input  wire logic [VERTEX_W-1:0]  left_vertex_i,
  input  wire logic [VERTEX_W-1:0]  right_vertex_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [VERTEX_W-1:0]       left_id_o,
  output logic [VERTEX_W-1:0]       partner_o,
  output logic                      has_partner_o,
  output logic [COUNT_W-1:0]        match_total_o,
  output logic                      last_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  bmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Graph storage, search state and result register
  bmm_dpath #(
    .MAX_LEFT  (MAX_LEFT),
    .MAX_RIGHT (MAX_RIGHT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .left_vertex_i  (left_vertex_i),
    .right_vertex_i (right_vertex_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_id_o      (left_id_o),
    .partner_o      (partner_o),
    .has_partner_o  (has_partner_o),
    .match_total_o  (match_total_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
